FILE: rtl/cme_pkg.sv
package cme_pkg;

  localparam int ROW_FIELD_LIMIT = 256;
  localparam int COL_FIELD_LIMIT = 512;

  localparam logic [8:0] SCREEN_ROWS_RESET = 9'd24;
  localparam logic [9:0] SCREEN_COLS_RESET = 10'd80;
  localparam logic [7:0] BOTTOM_RESET      = 8'd23;

  // Mode number that selects origin mode in the private set and reset commands.
  localparam logic [15:0] MODE_ORIGIN = 16'd6;

  typedef enum logic [0:0] {
    CFG_SCREEN_ROWS = 1'b0,
    CFG_SCREEN_COLS = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    REQ_UP        = 4'd0,
    REQ_DOWN      = 4'd1,
    REQ_FORWARD   = 4'd2,
    REQ_BACK      = 4'd3,
    REQ_NEXT_LINE = 4'd4,
    REQ_PREV_LINE = 4'd5,
    REQ_COLUMN    = 4'd6,
    REQ_POSITION  = 4'd7,
    REQ_ROW       = 4'd8,
    REQ_MARGINS   = 4'd9,
    REQ_PRIV_SET  = 4'd10,
    REQ_PRIV_RST  = 4'd11,
    REQ_SAVE      = 4'd12,
    REQ_RESTORE   = 4'd13
  } req_code_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [15:0] param_first;
    logic [15:0] param_second;
  } cme_cmd_t;

  typedef struct packed {
    logic [7:0] cursor_row;
    logic [8:0] cursor_col;
    logic [7:0] region_top;
    logic [7:0] region_bottom;
    logic       origin_on;
    logic       margins_rejected;
  } cme_result_t;

endpackage

FILE: rtl/cme_req_if.sv
interface cme_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [15:0] param_first;
  logic [15:0] param_second;

  modport source (output valid, output req_type, output param_first, output param_second,
                  input ready);
  modport sink (input valid, input req_type, input param_first, input param_second,
                output ready);
endinterface

FILE: rtl/cme_rsp_if.sv
interface cme_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] cursor_row;
  logic [8:0] cursor_col;
  logic [7:0] region_top;
  logic [7:0] region_bottom;
  logic       origin_on;
  logic       margins_rejected;

  modport source (output valid, output cursor_row, output cursor_col, output region_top,
                  output region_bottom, output origin_on, output margins_rejected,
                  input ready);
  modport sink (input valid, input cursor_row, input cursor_col, input region_top,
                input region_bottom, input origin_on, input margins_rejected,
                output ready);
endinterface

FILE: rtl/cursor_margin_engine.sv
// Cursor positioning and scroll margin engine.
// A command waits in the command register until the result register is free; then its
// result is registered; the next state and clamps are computed combinationally.
// Throughput: one command per cycle unless the result side stalls.
// Reset (rst, synchronous): cursor and saved cursor home, region 0..23, origin mode
// off, screen 24 rows by 80 columns, both register stages empty.
module cursor_margin_engine import cme_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [9:0] cfg_data,
  cme_req_if.sink    req,
  cme_rsp_if.source  rsp
);

  logic [8:0]  screen_rows;
  logic [9:0]  screen_cols;
  logic        cmd_valid;
  cme_cmd_t    cmd;
  logic        out_valid;
  cme_result_t out_data;
  cme_result_t result;
  logic        advance;
  logic        fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_rows <= SCREEN_ROWS_RESET;
      screen_cols <= SCREEN_COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_SCREEN_ROWS: screen_rows <= cfg_data[8:0];
        CFG_SCREEN_COLS: screen_cols <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The result register frees up whenever it is empty or being taken, so the
  // command register can refill in the same cycle.
  assign advance   = !out_valid || rsp.ready;
  assign fire      = cmd_valid && advance;
  assign req.ready = !cmd_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      cmd_valid <= 1'b1;
    end else if (advance) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd.req_type     <= req.req_type;
      cmd.param_first  <= req.param_first;
      cmd.param_second <= req.param_second;
    end
  end

  cme_exec #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .cmd         (cmd),
    .screen_rows (screen_rows),
    .screen_cols (screen_cols),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.cursor_row       = out_data.cursor_row;
  assign rsp.cursor_col       = out_data.cursor_col;
  assign rsp.region_top       = out_data.region_top;
  assign rsp.region_bottom    = out_data.region_bottom;
  assign rsp.origin_on        = out_data.origin_on;
  assign rsp.margins_rejected = out_data.margins_rejected;

endmodule

FILE: rtl/cme_exec.sv
module cme_exec import cme_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  cme_cmd_t    cmd,
  input  logic [8:0]  screen_rows,
  input  logic [9:0]  screen_cols,
  output cme_result_t result
);

  localparam int ROW_LIM = (MAX_ROWS < ROW_FIELD_LIMIT) ? MAX_ROWS : ROW_FIELD_LIMIT;
  localparam int COL_LIM = (MAX_COLS < COL_FIELD_LIMIT) ? MAX_COLS : COL_FIELD_LIMIT;
  localparam logic [8:0] ROW_LIM_W = 9'(ROW_LIM);
  localparam logic [9:0] COL_LIM_W = 10'(COL_LIM);

  logic [7:0] row_now, row_now_next;
  logic [8:0] col_now, col_now_next;
  logic [7:0] row_saved, row_saved_next;
  logic [8:0] col_saved, col_saved_next;
  logic [7:0] top_margin, top_margin_next;
  logic [7:0] bottom_margin, bottom_margin_next;
  logic       origin_flag, origin_flag_next;
  logic       rejected;

  logic [8:0]  rows_eff;
  logic [9:0]  cols_eff;
  logic [7:0]  rows_m1;
  logic [8:0]  cols_m1;
  logic [15:0] p1, p2;
  logic signed [17:0] p1_s, p2_s, row_s, col_s;
  logic signed [17:0] org_row;
  logic signed [17:0] tgt_row, tgt_col;
  logic        do_place;
  logic [15:0] bot_raw;
  logic [7:0]  bot_clamped;
  logic [16:0] top_req;

  function automatic logic [7:0] clamp_row(logic signed [17:0] v, logic [7:0] lim);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > $signed({10'd0, lim})) begin
      r = lim;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  function automatic logic [8:0] clamp_col(logic signed [17:0] v, logic [8:0] lim);
    logic [8:0] c;
    if (v < 0) begin
      c = 9'd0;
    end else if (v > $signed({9'd0, lim})) begin
      c = lim;
    end else begin
      c = v[8:0];
    end
    return c;
  endfunction

  always_comb begin
    if (screen_rows == 9'd0) begin
      rows_eff = 9'd1;
    end else if (screen_rows > ROW_LIM_W) begin
      rows_eff = ROW_LIM_W;
    end else begin
      rows_eff = screen_rows;
    end
    if (screen_cols == 10'd0) begin
      cols_eff = 10'd1;
    end else if (screen_cols > COL_LIM_W) begin
      cols_eff = COL_LIM_W;
    end else begin
      cols_eff = screen_cols;
    end
    rows_m1 = 8'(rows_eff - 9'd1);
    cols_m1 = 9'(cols_eff - 10'd1);
  end

  assign p1    = (cmd.param_first == 16'd0) ? 16'd1 : cmd.param_first;
  assign p2    = (cmd.param_second == 16'd0) ? 16'd1 : cmd.param_second;
  assign p1_s  = $signed({2'b00, p1});
  assign p2_s  = $signed({2'b00, p2});
  assign row_s = $signed({10'd0, row_now});
  assign col_s = $signed({9'd0, col_now});

  // In origin mode the row is taken relative to the region and held inside it.
  always_comb begin
    org_row = p1_s - 18'sd1;
    if (origin_flag) begin
      org_row = org_row + $signed({10'd0, top_margin});
      if (org_row > $signed({10'd0, bottom_margin})) begin
        org_row = $signed({10'd0, bottom_margin});
      end
    end
  end

  // The bottom margin defaults to the last row and is held to the screen.
  always_comb begin
    bot_raw = (cmd.param_second == 16'd0) ? {8'd0, rows_m1} : cmd.param_second - 16'd1;
    bot_clamped = (bot_raw > {8'd0, rows_m1}) ? rows_m1 : bot_raw[7:0];
    top_req = {1'b0, p1} - 17'd1;
  end

  always_comb begin
    row_now_next       = row_now;
    col_now_next       = col_now;
    row_saved_next     = row_saved;
    col_saved_next     = col_saved;
    top_margin_next    = top_margin;
    bottom_margin_next = bottom_margin;
    origin_flag_next   = origin_flag;
    rejected           = 1'b0;
    do_place           = 1'b0;
    tgt_row            = row_s;
    tgt_col            = col_s;

    case (req_code_t'(cmd.req_type))
      REQ_UP: begin
        do_place = 1'b1;
        tgt_row  = row_s - p1_s;
      end
      REQ_DOWN: begin
        do_place = 1'b1;
        tgt_row  = row_s + p1_s;
      end
      REQ_FORWARD: begin
        do_place = 1'b1;
        tgt_col  = col_s + p1_s;
      end
      REQ_BACK: begin
        do_place = 1'b1;
        tgt_col  = col_s - p1_s;
      end
      REQ_NEXT_LINE: begin
        do_place = 1'b1;
        tgt_row  = row_s + p1_s;
        tgt_col  = 18'sd0;
      end
      REQ_PREV_LINE: begin
        do_place = 1'b1;
        tgt_row  = row_s - p1_s;
        tgt_col  = 18'sd0;
      end
      REQ_COLUMN: begin
        do_place = 1'b1;
        tgt_col  = p1_s - 18'sd1;
      end
      REQ_POSITION: begin
        do_place = 1'b1;
        tgt_row  = org_row;
        tgt_col  = p2_s - 18'sd1;
      end
      REQ_ROW: begin
        do_place = 1'b1;
        tgt_row  = org_row;
      end
      REQ_MARGINS: begin
        if (top_req >= {9'd0, bot_clamped}) begin
          rejected = 1'b1;
        end else begin
          top_margin_next    = top_req[7:0];
          bottom_margin_next = bot_clamped;
          do_place           = 1'b1;
          tgt_row            = origin_flag ? $signed({10'd0, top_req[7:0]}) : 18'sd0;
          tgt_col            = 18'sd0;
        end
      end
      REQ_PRIV_SET, REQ_PRIV_RST: begin
        if (cmd.param_first == MODE_ORIGIN) begin
          origin_flag_next = (req_code_t'(cmd.req_type) == REQ_PRIV_SET);
          do_place         = 1'b1;
          tgt_row          = origin_flag_next ? $signed({10'd0, top_margin}) : 18'sd0;
          tgt_col          = 18'sd0;
        end
      end
      REQ_SAVE: begin
        row_saved_next = row_now;
        col_saved_next = col_now;
      end
      REQ_RESTORE: begin
        do_place = 1'b1;
        tgt_row  = $signed({10'd0, row_saved});
        tgt_col  = $signed({9'd0, col_saved});
      end
      default: begin
      end
    endcase

    if (do_place) begin
      row_now_next = clamp_row(tgt_row, rows_m1);
      col_now_next = clamp_col(tgt_col, cols_m1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_now       <= 8'd0;
      col_now       <= 9'd0;
      row_saved     <= 8'd0;
      col_saved     <= 9'd0;
      top_margin    <= 8'd0;
      bottom_margin <= BOTTOM_RESET;
      origin_flag   <= 1'b0;
    end else if (fire) begin
      row_now       <= row_now_next;
      col_now       <= col_now_next;
      row_saved     <= row_saved_next;
      col_saved     <= col_saved_next;
      top_margin    <= top_margin_next;
      bottom_margin <= bottom_margin_next;
      origin_flag   <= origin_flag_next;
    end
  end

  assign result.cursor_row       = row_now_next;
  assign result.cursor_col       = col_now_next;
  assign result.region_top       = top_margin_next;
  assign result.region_bottom    = bottom_margin_next;
  assign result.origin_on        = origin_flag_next;
  assign result.margins_rejected = rejected;

endmodule

FILE: tb/cme_checker.sv
module cme_checker import cme_pkg::*; #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [9:0] cfg_data,
  cme_req_if         req,
  cme_rsp_if         rsp,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_LIMIT = (MAX_ROWS < ROW_FIELD_LIMIT) ? MAX_ROWS : ROW_FIELD_LIMIT;
  localparam int COL_LIMIT = (MAX_COLS < COL_FIELD_LIMIT) ? MAX_COLS : COL_FIELD_LIMIT;
  localparam int PRINT_LIMIT = 100;

  logic [8:0] screen_rows;
  logic [9:0] screen_cols;
  logic [7:0] cur_row;
  logic [8:0] cur_col;
  logic [7:0] saved_row;
  logic [8:0] saved_col;
  logic [7:0] top_margin;
  logic [7:0] bottom_margin;
  logic       origin_mode;

  cme_result_t cursor_reports_due[$];

  function automatic int screen_height();
    int h;
    h = int'(screen_rows);
    if (h < 1) h = 1;
    if (h > ROW_LIMIT) h = ROW_LIMIT;
    return h;
  endfunction

  function automatic int screen_width();
    int w;
    w = int'(screen_cols);
    if (w < 1) w = 1;
    if (w > COL_LIMIT) w = COL_LIMIT;
    return w;
  endfunction

  function automatic void move_to(int r, int c);
    if (r < 0) r = 0;
    if (c < 0) c = 0;
    if (r >= screen_height()) r = screen_height() - 1;
    if (c >= screen_width()) c = screen_width() - 1;
    cur_row = r[7:0];
    cur_col = c[8:0];
  endfunction

  // In origin mode the row counts from the region top and may not pass its bottom.
  function automatic void move_in_region(int r, int c);
    if (origin_mode) begin
      if (r < 0) r = 0;
      r = r + int'(top_margin);
      if (r > int'(bottom_margin)) r = int'(bottom_margin);
    end
    move_to(r, c);
  endfunction

  function automatic cme_result_t predict_cursor(cme_cmd_t c);
    int p1;
    int p2;
    int r;
    int k;
    int rows;
    int top;
    int bot;
    cme_result_t res;
    p1 = (c.param_first == 16'd0) ? 1 : int'(c.param_first);
    p2 = (c.param_second == 16'd0) ? 1 : int'(c.param_second);
    r = int'(cur_row);
    k = int'(cur_col);
    res.margins_rejected = 1'b0;
    case (c.req_type)
      REQ_UP:        move_to(r - p1, k);
      REQ_DOWN:      move_to(r + p1, k);
      REQ_FORWARD:   move_to(r, k + p1);
      REQ_BACK:      move_to(r, k - p1);
      REQ_NEXT_LINE: move_to(r + p1, 0);
      REQ_PREV_LINE: move_to(r - p1, 0);
      REQ_COLUMN:    move_to(r, p1 - 1);
      REQ_POSITION:  move_in_region(p1 - 1, p2 - 1);
      REQ_ROW:       move_in_region(p1 - 1, k);
      REQ_MARGINS: begin
        rows = screen_height();
        top = p1 - 1;
        bot = ((c.param_second == 16'd0) ? rows : int'(c.param_second)) - 1;
        if (bot >= rows) bot = rows - 1;
        if (top >= bot) begin
          res.margins_rejected = 1'b1;
        end else begin
          top_margin = top[7:0];
          bottom_margin = bot[7:0];
          move_to(origin_mode ? top : 0, 0);
        end
      end
      REQ_PRIV_SET, REQ_PRIV_RST: begin
        if (c.param_first == MODE_ORIGIN) begin
          origin_mode = (c.req_type == REQ_PRIV_SET);
          move_to(origin_mode ? int'(top_margin) : 0, 0);
        end
      end
      REQ_SAVE: begin
        saved_row = cur_row;
        saved_col = cur_col;
      end
      REQ_RESTORE:   move_to(int'(saved_row), int'(saved_col));
      default: ;
    endcase
    res.cursor_row = cur_row;
    res.cursor_col = cur_col;
    res.region_top = top_margin;
    res.region_bottom = bottom_margin;
    res.origin_on = origin_mode;
    return res;
  endfunction

  function automatic void flag_field(string name, logic [15:0] want, logic [15:0] got);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    mismatches++;
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    cme_cmd_t    cmd;
    cme_result_t got;
    cme_result_t want;
    if (rst) begin
      screen_rows = SCREEN_ROWS_RESET;
      screen_cols = SCREEN_COLS_RESET;
      cur_row = '0;
      cur_col = '0;
      saved_row = '0;
      saved_col = '0;
      top_margin = '0;
      bottom_margin = BOTTOM_RESET;
      origin_mode = 1'b0;
      cursor_reports_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SCREEN_ROWS) screen_rows = cfg_data[8:0];
        else screen_cols = cfg_data;
      end
      // A result can never belong to the command accepted at the same edge, so pop first.
      if (rsp.valid && rsp.ready) begin
        got.cursor_row = rsp.cursor_row;
        got.cursor_col = rsp.cursor_col;
        got.region_top = rsp.region_top;
        got.region_bottom = rsp.region_bottom;
        got.origin_on = rsp.origin_on;
        got.margins_rejected = rsp.margins_rejected;
        if (cursor_reports_due.size() == 0) begin
          if (mismatches < PRINT_LIMIT)
            $display("%0t: result with nothing outstanding, expected none, actual %0h",
                     $time, got);
          mismatches++;
        end else begin
          want = cursor_reports_due.pop_front();
          if (got.cursor_row !== want.cursor_row)
            flag_field("cursor_row", want.cursor_row, got.cursor_row);
          if (got.cursor_col !== want.cursor_col)
            flag_field("cursor_col", want.cursor_col, got.cursor_col);
          if (got.region_top !== want.region_top)
            flag_field("region_top", want.region_top, got.region_top);
          if (got.region_bottom !== want.region_bottom)
            flag_field("region_bottom", want.region_bottom, got.region_bottom);
          if (got.origin_on !== want.origin_on)
            flag_field("origin_on", want.origin_on, got.origin_on);
          if (got.margins_rejected !== want.margins_rejected)
            flag_field("margins_rejected", want.margins_rejected, got.margins_rejected);
        end
      end
      if (req.valid && req.ready) begin
        cmd.req_type = req.req_type;
        cmd.param_first = req.param_first;
        cmd.param_second = req.param_second;
        cursor_reports_due.push_back(predict_cursor(cmd));
      end
    end
    outstanding = cursor_reports_due.size();
  end

endmodule

FILE: tb/tb.sv
module tb import cme_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 512;
  localparam int CYCLE_LIMIT = 250000;
  localparam logic [3:0] REQ_SPARE_LO = 4'd14;
  localparam logic [3:0] REQ_SPARE_HI = 4'd15;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [9:0] cfg_data;
  int         mismatches;
  int         outstanding;
  int         idle_odds;
  int         cur_rows;
  int         cur_cols;
  int         cycle_count = 0;

  cme_req_if req_if ();
  cme_rsp_if rsp_if ();

  cursor_margin_engine #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_if),
    .rsp(rsp_if)
  );

  cme_checker #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_if),
    .rsp(rsp_if),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The result side stalls in bursts whenever idling is enabled for the phase.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic send_cmd(input logic [3:0] code, input logic [15:0] a, input logic [15:0] b);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= code;
    req_if.param_first <= a;
    req_if.param_second <= b;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  // Writes both screen registers once the pipeline has drained, then picks the idling mix.
  task automatic set_screen(input logic [9:0] rows, input logic [9:0] cols);
    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SCREEN_ROWS;
    cfg_data <= rows;
    @(negedge clk);
    cfg_index <= CFG_SCREEN_COLS;
    cfg_data <= cols;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_rows = int'(rows[8:0]);
    if (cur_rows < 1) cur_rows = 1;
    if (cur_rows > MAX_ROWS) cur_rows = MAX_ROWS;
    cur_cols = int'(cols);
    if (cur_cols < 1) cur_cols = 1;
    if (cur_cols > MAX_COLS) cur_cols = MAX_COLS;
    idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 10);
  endtask

  function automatic logic [15:0] pick_param(int span);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(1, span + 2));
    endcase
  endfunction

  task automatic random_commands(int count);
    logic [3:0]  code;
    logic [15:0] a;
    logic [15:0] b;
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) code = 4'($urandom_range(0, 15));
      else code = 4'($urandom_range(int'(REQ_UP), int'(REQ_RESTORE)));
      if (code == REQ_FORWARD || code == REQ_BACK || code == REQ_COLUMN)
        a = pick_param(cur_cols);
      else
        a = pick_param(cur_rows);
      b = pick_param((code == REQ_POSITION) ? cur_cols : cur_rows);
      if ((code == REQ_PRIV_SET || code == REQ_PRIV_RST) && $urandom_range(0, 3) != 0)
        a = MODE_ORIGIN;
      send_cmd(code, a, b);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_SCREEN_ROWS;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_UP;
    req_if.param_first = '0;
    req_if.param_second = '0;
    idle_odds = 0;
    cur_rows = int'(SCREEN_ROWS_RESET);
    cur_cols = int'(SCREEN_COLS_RESET);
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_odds = 4;
    send_cmd(REQ_UP, 16'd0, 16'd0);
    send_cmd(REQ_DOWN, 16'hFFFF, 16'd0);
    send_cmd(REQ_FORWARD, 16'hFFFF, 16'hFFFF);
    send_cmd(REQ_BACK, 16'd0, 16'd0);
    send_cmd(REQ_PREV_LINE, 16'd0, 16'd0);
    send_cmd(REQ_NEXT_LINE, 16'hFFFF, 16'd0);
    send_cmd(REQ_BACK, 16'hFFFF, 16'd0);
    send_cmd(REQ_COLUMN, 16'hFFFF, 16'd0);
    send_cmd(REQ_COLUMN, 16'd0, 16'd0);
    send_cmd(REQ_POSITION, 16'hFFFF, 16'hFFFF);
    send_cmd(REQ_SAVE, 16'd0, 16'd0);
    send_cmd(REQ_POSITION, 16'd0, 16'd0);
    send_cmd(REQ_ROW, 16'd12, 16'd0);
    send_cmd(REQ_MARGINS, 16'd5, 16'd10);
    // Rejected regions: top below bottom, and a one-row region at the last row.
    send_cmd(REQ_MARGINS, 16'd10, 16'd5);
    send_cmd(REQ_MARGINS, 16'd24, 16'd0);
    send_cmd(REQ_MARGINS, 16'd3, 16'hFFFF);
    send_cmd(REQ_PRIV_SET, MODE_ORIGIN, 16'd0);
    send_cmd(REQ_POSITION, 16'hFFFF, 16'd0);
    send_cmd(REQ_ROW, 16'd0, 16'd0);
    send_cmd(REQ_PRIV_SET, 16'd7, 16'd0);
    send_cmd(REQ_RESTORE, 16'd0, 16'd0);
    send_cmd(REQ_PRIV_RST, MODE_ORIGIN, 16'd0);
    send_cmd(REQ_MARGINS, 16'd0, 16'd0);
    send_cmd(REQ_SPARE_LO, 16'hFFFF, 16'hFFFF);
    send_cmd(REQ_SPARE_HI, 16'd1, 16'd1);
    random_commands(200);

    // A large screen first, so that the saved cursor lies outside the tiny screens after it.
    set_screen(10'd256, 10'd512);
    random_commands(250);
    set_screen(10'd1, 10'd1);
    random_commands(150);
    set_screen(10'd0, 10'd0);
    random_commands(100);
    set_screen(10'h3FF, 10'h3FF);
    random_commands(100);
    repeat (4) begin
      set_screen(10'($urandom_range(2, 60)), 10'($urandom_range(2, 140)));
      random_commands(200);
    end
    set_screen(10'd24, 10'd80);
    idle_odds = 0;
    random_commands(150);

    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: cursor_margin_engine.f
rtl/cme_pkg.sv
rtl/cme_req_if.sv
rtl/cme_rsp_if.sv
rtl/cme_exec.sv
rtl/cursor_margin_engine.sv
tb/cme_checker.sv
tb/tb.sv
